FILE: rtl/core/smpb_pkg.sv
// Shared types, constants and control structs for the skin matrix palette builder.
package smpb_pkg;

    localparam int MAX_BONES = 256;
    localparam int BONE_W    = $clog2(MAX_BONES);
    localparam int ADDR_W    = BONE_W + 2;
    localparam int LIM_W     = BONE_W + 2;
    localparam int ELEM_W    = 32;
    localparam int ROW_W     = 4 * ELEM_W;
    localparam int CNT_W     = 9;
    localparam int PAR_W     = 9;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [63:0]       prod_t;
    typedef logic signed [64:0]       psum_t;
    typedef logic signed [65:0]       fsum_t;

    typedef enum logic
    {
        DOT_WROW = 1'b0,
        DOT_SKIN = 1'b1
    } dot_mode_t;

    typedef struct packed
    {
        logic      accept;
        logic      load_root;
        logic      rd_en;
        logic [1:0] rd_row;
        logic      dot_issue;
        dot_mode_t dot_mode;
        logic [1:0] dot_c;
        logic [1:0] dot_k;
        logic      pend_wr;
        logic      commit_en;
        logic [1:0] commit_row;
    } smpb_cmd_t;

    typedef struct packed
    {
        logic drop;
        logic root;
        logic row3;
        logic busy;
    } smpb_stat_t;

endpackage

FILE: rtl/core/smpb_ctrl.sv
// Control state machine that sequences reads, dot products, results and commits.
module smpb_ctrl
    import smpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] out_row,
    output logic       bone_done,
    output smpb_cmd_t  cmd,
    input  smpb_stat_t stat
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_RWAIT,
        S_WDOT,
        S_WDRAIN,
        S_ROWEND,
        S_SKDOT,
        S_SKDRAIN,
        S_OUT,
        S_COMMIT
    } state_t;

    state_t     state_reg;
    logic [1:0] cnt_reg;
    logic [1:0] col_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_row   = col_reg;
    assign bone_done = (col_reg == 2'd3);

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == S_IDLE) && in_valid;
        cmd.load_root  = (state_reg == S_DECIDE) && !stat.drop && stat.root;
        cmd.rd_en      = (state_reg == S_READ);
        cmd.rd_row     = cnt_reg;
        cmd.dot_issue  = (state_reg == S_WDOT) || (state_reg == S_SKDOT);
        cmd.dot_mode   = (state_reg == S_SKDOT) ? DOT_SKIN : DOT_WROW;
        cmd.dot_c      = (state_reg == S_SKDOT) ? col_reg : cnt_reg;
        cmd.dot_k      = cnt_reg;
        cmd.pend_wr    = (state_reg == S_ROWEND) && !stat.row3;
        cmd.commit_en  = (state_reg == S_COMMIT);
        cmd.commit_row = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg <= '0;
                    if (stat.drop)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (stat.root)
                    begin
                        state_reg <= S_ROWEND;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= S_RWAIT;
                    end
                end
                S_RWAIT:
                begin
                    state_reg <= S_WDOT;
                end
                S_WDOT:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= S_WDRAIN;
                    end
                end
                S_WDRAIN:
                begin
                    if (!stat.busy)
                    begin
                        state_reg <= S_ROWEND;
                    end
                end
                S_ROWEND:
                begin
                    cnt_reg <= '0;
                    col_reg <= '0;
                    state_reg <= stat.row3 ? S_SKDOT : S_IDLE;
                end
                S_SKDOT:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= S_SKDRAIN;
                    end
                end
                S_SKDRAIN:
                begin
                    if (!stat.busy)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        cnt_reg <= '0;
                        if (col_reg == 2'd3)
                        begin
                            state_reg <= S_COMMIT;
                        end
                        else
                        begin
                            col_reg   <= col_reg + 2'd1;
                            state_reg <= S_SKDOT;
                        end
                    end
                end
                S_COMMIT:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/smpb_datapath.sv
// Datapath: input latches, world store, pending rows and the four-multiplier dot unit.
module smpb_datapath
    import smpb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CNT_W-1:0]        bone_count,
    input  logic [7:0]              bone_index,
    input  logic signed [PAR_W-1:0] parent_index,
    input  logic [1:0]              row_number,
    input  elem_t                   local_c0,
    input  elem_t                   local_c1,
    input  elem_t                   local_c2,
    input  elem_t                   local_c3,
    input  elem_t                   bind_c0,
    input  elem_t                   bind_c1,
    input  elem_t                   bind_c2,
    input  elem_t                   bind_c3,
    output logic [7:0]              out_bone,
    output elem_t                   skin_e0,
    output elem_t                   skin_e1,
    output elem_t                   skin_e2,
    output elem_t                   skin_e3,
    input  smpb_cmd_t               cmd,
    output smpb_stat_t              stat
);

    localparam fsum_t RND = fsum_t'(66'sh8000);

    logic [CNT_W-1:0]        bcount_reg;
    logic [7:0]              bone_reg;
    logic signed [PAR_W-1:0] parent_reg;
    logic [1:0]              row_reg;
    elem_t                   lrow_reg [4];
    elem_t                   brow_reg [4];
    elem_t                   pm_reg   [4][4];
    elem_t                   wrow_reg [4];
    elem_t                   pw_reg   [3][4];
    elem_t                   pb_reg   [3][4];
    elem_t                   oute_reg [4];
    logic [MAX_BONES-1:0]    vbit_reg;

    logic [ROW_W-1:0] mem [MAX_BONES*4];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_en_q_reg;
    logic [1:0]       rd_row_q_reg;

    logic [LIM_W-1:0]  lim;
    logic [BONE_W-1:0] par_idx;
    logic [BONE_W-1:0] bone_idx;
    logic [ROW_W-1:0]  commit_data;

    elem_t a_sel [4];
    elem_t b_sel [4];

    prod_t      p_reg [4];
    logic       s1_vld_reg;
    dot_mode_t  s1_mode_reg;
    logic [1:0] s1_idx_reg;
    psum_t      s01_reg;
    psum_t      s23_reg;
    logic       s2_vld_reg;
    dot_mode_t  s2_mode_reg;
    logic [1:0] s2_idx_reg;
    fsum_t      tot;
    logic signed [49:0] q;
    elem_t      dot_res;

    assign lim = (LIM_W'(bcount_reg) < LIM_W'(MAX_BONES)) ? LIM_W'(bcount_reg)
                                                           : LIM_W'(MAX_BONES);
    assign par_idx  = parent_reg[BONE_W-1:0];
    assign bone_idx = bone_reg[BONE_W-1:0];

    assign stat.drop = (LIM_W'(bone_reg) >= lim);
    assign stat.root = parent_reg[PAR_W-1] ||
                       (LIM_W'(parent_reg[PAR_W-2:0]) >= lim);
    assign stat.row3 = (row_reg == 2'd3);
    assign stat.busy = s1_vld_reg || s2_vld_reg;

    assign out_bone = bone_reg;
    assign skin_e0  = oute_reg[0];
    assign skin_e1  = oute_reg[1];
    assign skin_e2  = oute_reg[2];
    assign skin_e3  = oute_reg[3];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            case (cmd.commit_row)
                2'd0:    commit_data[j*ELEM_W +: ELEM_W] = pw_reg[0][j];
                2'd1:    commit_data[j*ELEM_W +: ELEM_W] = pw_reg[1][j];
                2'd2:    commit_data[j*ELEM_W +: ELEM_W] = pw_reg[2][j];
                default: commit_data[j*ELEM_W +: ELEM_W] = wrow_reg[j];
            endcase
        end
    end

    // The world store holds one matrix row per address; a bone never committed reads as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.commit_en)
        begin
            mem[{bone_idx, cmd.commit_row}] <= commit_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[{par_idx, cmd.rd_row}];
        end
    end

    // Operand selection for the shared dot unit.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (cmd.dot_mode == DOT_WROW)
            begin
                a_sel[j] = lrow_reg[j];
                b_sel[j] = pm_reg[j][cmd.dot_c];
            end
            else
            begin
                case (cmd.dot_k)
                    2'd0:    a_sel[j] = pb_reg[0][j];
                    2'd1:    a_sel[j] = pb_reg[1][j];
                    2'd2:    a_sel[j] = pb_reg[2][j];
                    default: a_sel[j] = brow_reg[j];
                endcase
                case (j)
                    0:       b_sel[j] = pw_reg[0][cmd.dot_c];
                    1:       b_sel[j] = pw_reg[1][cmd.dot_c];
                    2:       b_sel[j] = pw_reg[2][cmd.dot_c];
                    default: b_sel[j] = wrow_reg[cmd.dot_c];
                endcase
            end
        end
    end

    // Round to nearest with ties up, then saturate to the signed 32-bit range.
    always_comb
    begin
        tot = fsum_t'(s01_reg) + fsum_t'(s23_reg) + RND;
        q   = tot[65:16];
        if (!q[49] && (|q[48:31]))
        begin
            dot_res = elem_t'(32'sh7FFF_FFFF);
        end
        else if (q[49] && !(&q[48:31]))
        begin
            dot_res = elem_t'(32'sh8000_0000);
        end
        else
        begin
            dot_res = q[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            p_reg[j] <= prod_t'(a_sel[j]) * prod_t'(b_sel[j]);
        end
        s1_mode_reg <= cmd.dot_mode;
        s1_idx_reg  <= (cmd.dot_mode == DOT_WROW) ? cmd.dot_c : cmd.dot_k;
        s01_reg     <= psum_t'(p_reg[0]) + psum_t'(p_reg[1]);
        s23_reg     <= psum_t'(p_reg[2]) + psum_t'(p_reg[3]);
        s2_mode_reg <= s1_mode_reg;
        s2_idx_reg  <= s1_idx_reg;
        rd_row_q_reg <= cmd.rd_row;

        if (cmd.accept)
        begin
            bone_reg   <= bone_index;
            parent_reg <= parent_index;
            row_reg    <= row_number;
            lrow_reg[0] <= local_c0;
            lrow_reg[1] <= local_c1;
            lrow_reg[2] <= local_c2;
            lrow_reg[3] <= local_c3;
            brow_reg[0] <= bind_c0;
            brow_reg[1] <= bind_c1;
            brow_reg[2] <= bind_c2;
            brow_reg[3] <= bind_c3;
        end

        if (rd_en_q_reg)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pm_reg[rd_row_q_reg][j] <= vbit_reg[par_idx] ?
                                           rd_data_reg[j*ELEM_W +: ELEM_W] : '0;
            end
        end

        if (cmd.load_root)
        begin
            for (int j = 0; j < 4; j++)
            begin
                wrow_reg[j] <= lrow_reg[j];
            end
        end
        else if (s2_vld_reg && (s2_mode_reg == DOT_WROW))
        begin
            wrow_reg[s2_idx_reg] <= dot_res;
        end

        if (s2_vld_reg && (s2_mode_reg == DOT_SKIN))
        begin
            oute_reg[s2_idx_reg] <= dot_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg  <= '0;
            vbit_reg    <= '0;
            rd_en_q_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pw_reg[r][j] <= '0;
                    pb_reg[r][j] <= '0;
                end
            end
        end
        else
        begin
            rd_en_q_reg <= cmd.rd_en;
            s1_vld_reg  <= cmd.dot_issue;
            s2_vld_reg  <= s1_vld_reg;
            if (cfg_valid)
            begin
                bcount_reg <= bone_count;
            end
            if (cmd.commit_en && (cmd.commit_row == 2'd3))
            begin
                vbit_reg[bone_idx] <= 1'b1;
            end
            if (cmd.pend_wr)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pw_reg[row_reg][j] <= wrow_reg[j];
                    pb_reg[row_reg][j] <= brow_reg[j];
                end
            end
        end
    end

endmodule

FILE: rtl/core/skin_matrix_palette_builder_core.sv
// Sequence: a dropped item is only decoded; a root row 0..2 is decoded and stored as a pending row;
// a child row makes four world store reads, a read wait, four dot issues and a drain first.
// A row 3 item computes its first result once its world row is ready and each
// further result once the previous one is taken; the world commit then writes the four rows.
// One item is in work at a time; the four-multiplier dot unit and the store port set the rate.
// Reset clears the bone count, pending rows and per-bone valid bits; the store needs no sweep.
module skin_matrix_palette_builder_core
    import smpb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CNT_W-1:0]        bone_count,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              bone_index,
    input  logic signed [PAR_W-1:0] parent_index,
    input  logic [1:0]              row_number,
    input  elem_t                   local_c0,
    input  elem_t                   local_c1,
    input  elem_t                   local_c2,
    input  elem_t                   local_c3,
    input  elem_t                   bind_c0,
    input  elem_t                   bind_c1,
    input  elem_t                   bind_c2,
    input  elem_t                   bind_c3,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_bone,
    output logic [1:0]              out_row,
    output elem_t                   skin_e0,
    output elem_t                   skin_e1,
    output elem_t                   skin_e2,
    output elem_t                   skin_e3,
    output logic                    bone_done
);

    smpb_cmd_t  cmd;
    smpb_stat_t stat;

    assign cfg_ready = 1'b1;

    smpb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .bone_done (bone_done),
        .cmd       (cmd),
        .stat      (stat)
    );

    smpb_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .bone_count   (bone_count),
        .bone_index   (bone_index),
        .parent_index (parent_index),
        .row_number   (row_number),
        .local_c0     (local_c0),
        .local_c1     (local_c1),
        .local_c2     (local_c2),
        .local_c3     (local_c3),
        .bind_c0      (bind_c0),
        .bind_c1      (bind_c1),
        .bind_c2      (bind_c2),
        .bind_c3      (bind_c3),
        .out_bone     (out_bone),
        .skin_e0      (skin_e0),
        .skin_e1      (skin_e1),
        .skin_e2      (skin_e2),
        .skin_e3      (skin_e3),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

FILE: rtl/core/smpb_checker.sv
// Port-level checker for the skin matrix palette builder, bound to the top level.
module smpb_checker
    import smpb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] out_row,
    input elem_t      skin_e0,
    input logic       bone_done
);

    // A pending result blocks new requests.
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while a result is pending");

    a_done_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bone_done == (out_row == 2'd3)))
        else $error("bone_done does not match the last row");

    // Results are spaced out by the dot product work between rows.
    a_gap_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (out_row != 2'd3)) |=> !out_valid)
        else $error("result row followed without compute gap");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_row) && $stable(skin_e0)))
        else $error("stalled result changed");

endmodule

bind skin_matrix_palette_builder_core smpb_checker u_smpb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .skin_e0   (skin_e0),
    .bone_done (bone_done)
);

FILE: tb/skin_matrix_palette_builder_core_tb.sv
// Self-checking testbench for the skin matrix palette builder core.
`timescale 1ns / 100ps

module skin_matrix_palette_builder_core_tb;
    import smpb_pkg::*;

    typedef struct packed
    {
        logic [7:0] bone;
        logic [1:0] row;
        elem_t      e0;
        elem_t      e1;
        elem_t      e2;
        elem_t      e3;
        logic       done;
    } skin_row_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CNT_W-1:0]        bone_count;
    logic                    in_valid;
    logic                    in_stall;
    logic [7:0]              bone_index;
    logic signed [PAR_W-1:0] parent_index;
    logic [1:0]              row_number;
    elem_t                   local_c0, local_c1, local_c2, local_c3;
    elem_t                   bind_c0, bind_c1, bind_c2, bind_c3;
    logic                    out_valid;
    logic                    out_stall;
    logic [7:0]              out_bone;
    logic [1:0]              out_row;
    elem_t                   skin_e0, skin_e1, skin_e2, skin_e3;
    logic                    bone_done;

    // Predictor state.
    int unsigned model_bone_count;
    elem_t       world_mem [MAX_BONES][16];
    elem_t       pend_world [12];
    elem_t       pend_bind [12];

    skin_row_t   skin_rows_due [$];
    int          error_count;
    int          idle_cycles;
    int          results_seen;
    int          items_sent;
    bit          hold_off;
    bit          busy_stall;

    skin_matrix_palette_builder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .bone_count  (bone_count),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bone_index  (bone_index),
        .parent_index(parent_index),
        .row_number  (row_number),
        .local_c0    (local_c0),
        .local_c1    (local_c1),
        .local_c2    (local_c2),
        .local_c3    (local_c3),
        .bind_c0     (bind_c0),
        .bind_c1     (bind_c1),
        .bind_c2     (bind_c2),
        .bind_c3     (bind_c3),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_bone    (out_bone),
        .out_row     (out_row),
        .skin_e0     (skin_e0),
        .skin_e1     (skin_e1),
        .skin_e2     (skin_e2),
        .skin_e3     (skin_e3),
        .bone_done   (bone_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Four-term Q16.16 dot product, rounded half up and saturated.
    function automatic elem_t fixed_dot(elem_t a0, elem_t a1, elem_t a2, elem_t a3,
                                        elem_t b0, elem_t b1, elem_t b2, elem_t b3);
        logic signed [67:0] acc;
        logic signed [67:0] scaled;
        acc = 68'(64'(a0) * 64'(b0)) + 68'(64'(a1) * 64'(b1))
            + 68'(64'(a2) * 64'(b2)) + 68'(64'(a3) * 64'(b3));
        scaled = (acc + 68'sd32768) >>> 16;
        if (scaled > 68'sd2147483647)
            return 32'sh7fffffff;
        if (scaled < -68'sd2147483648)
            return 32'sh80000000;
        return elem_t'(scaled);
    endfunction

    // Works out the skin rows that one accepted request produces.
    task automatic predict_skin_rows(logic [7:0] bone, logic signed [8:0] parent,
                                     logic [1:0] row, elem_t lrow [4], elem_t brow [4]);
        int unsigned lim;
        elem_t       wrow [4];
        elem_t       wm [16];
        elem_t       bm [16];
        skin_row_t   r;
        elem_t       e [4];
        lim = (model_bone_count < MAX_BONES) ? model_bone_count : MAX_BONES;
        if (bone >= lim)
            return;
        if (parent >= 0 && int'(parent) < int'(lim))
        begin
            for (int c = 0; c < 4; c++)
                wrow[c] = fixed_dot(lrow[0], lrow[1], lrow[2], lrow[3],
                                    world_mem[parent][c], world_mem[parent][4 + c],
                                    world_mem[parent][8 + c], world_mem[parent][12 + c]);
        end
        else
            wrow = lrow;
        if (row < 3)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pend_world[row * 4 + k] = wrow[k];
                pend_bind[row * 4 + k]  = brow[k];
            end
            return;
        end
        for (int k = 0; k < 12; k++)
        begin
            wm[k] = pend_world[k];
            bm[k] = pend_bind[k];
        end
        for (int k = 0; k < 4; k++)
        begin
            wm[12 + k] = wrow[k];
            bm[12 + k] = brow[k];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                e[k] = fixed_dot(bm[k * 4], bm[k * 4 + 1], bm[k * 4 + 2], bm[k * 4 + 3],
                                 wm[c], wm[4 + c], wm[8 + c], wm[12 + c]);
            r.bone = bone;
            r.row  = 2'(c);
            r.e0   = e[0];
            r.e1   = e[1];
            r.e2   = e[2];
            r.e3   = e[3];
            r.done = (c == 3);
            skin_rows_due.push_back(r);
        end
        for (int k = 0; k < 16; k++)
            world_mem[bone][k] = wm[k];
    endtask

    task automatic random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return;
        else if (roll < 95)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic send_bone_row(logic [7:0] bone, logic signed [8:0] parent, logic [1:0] row,
                                 elem_t lrow [4], elem_t brow [4], bit no_gap = 0);
        if (!no_gap)
            random_gap();
        // Valid was just dropped in this time step; raise it again on the next edge.
        if (in_valid)
            @(posedge clk);
        in_valid     <= 1'b1;
        bone_index   <= bone;
        parent_index <= parent;
        row_number   <= row;
        local_c0 <= lrow[0];
        local_c1 <= lrow[1];
        local_c2 <= lrow[2];
        local_c3 <= lrow[3];
        bind_c0  <= brow[0];
        bind_c1  <= brow[1];
        bind_c2  <= brow[2];
        bind_c3  <= brow[3];
        do
            @(posedge clk);
        while (in_stall);
        predict_skin_rows(bone, parent, row, lrow, brow);
        items_sent++;
        in_valid <= 1'b0;
    endtask

    task automatic write_bone_count(int unsigned value);
        // Let a trailing dropped or pending-row request finish first.
        while (skin_rows_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid  <= 1'b1;
        bone_count <= CNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_bone_count = value;
    endtask

    function automatic elem_t random_elem();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            3: return 32'sh00010000;
            default: return elem_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
        endcase
    endfunction

    task automatic send_random_bone(logic [7:0] bone);
        elem_t             lrow [4];
        elem_t             brow [4];
        logic signed [8:0] parent;
        int                roll;
        roll = $urandom_range(0, 9);
        if (roll < 3 || bone == 0)
            parent = -9'sd1;
        else if (roll < 8)
            parent = 9'($urandom_range(0, bone - 1));
        else
            parent = 9'($urandom());
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                lrow[k] = random_elem();
                brow[k] = random_elem();
            end
            send_bone_row(bone, parent, 2'(r), lrow, brow);
        end
    endtask

    task automatic test_directed_extremes();
        elem_t lrow [4];
        elem_t brow [4];
        write_bone_count(4);
        // Identity root bone, then a child reading it.
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                lrow[k] = (k == r) ? 32'sh00010000 : 32'sh0;
                brow[k] = (k == r) ? 32'sh00020000 : 32'sh0;
            end
            send_bone_row(8'd0, -9'sd1, 2'(r), lrow, brow);
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                lrow[k] = (r[0]) ? 32'sh7fffffff : 32'sh80000000;
                brow[k] = (k[0]) ? 32'sh80000000 : 32'sh7fffffff;
            end
            send_bone_row(8'd1, 9'sd0, 2'(r), lrow, brow);
        end
        // A parent after this bone, never committed, reads as zero; then the bone is its own parent.
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                lrow[k] = 32'sh00008000;
                brow[k] = -32'sh00008000;
            end
            send_bone_row(8'd2, 9'sd3, 2'(r), lrow, brow);
        end
        send_bone_row(8'd2, 9'sd2, 2'd3, lrow, brow);
        // Parent at or above the bone count is a root; dropped bone does nothing.
        send_bone_row(8'd3, 9'sd255, 2'd3, lrow, brow);
        send_bone_row(8'd255, 9'sd0, 2'd3, lrow, brow);
        send_bone_row(8'd4, 9'sd0, 2'd0, lrow, brow);
        // Row 3 alone, with rows left from another bone; the parent is the most negative value.
        send_bone_row(8'd1, 9'sh100, 2'd3, lrow, brow);
        write_bone_count(0);
        send_bone_row(8'd0, 9'sd0, 2'd3, lrow, brow);
    endtask

    task automatic test_random_skeletons(int unsigned n_items);
        int unsigned lim;
        int          roll;
        elem_t       lrow [4];
        elem_t       brow [4];
        while (items_sent < n_items)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                write_bone_count($urandom_range(0, 2) == 0 ? 256 : $urandom_range(1, 511));
            else if (roll == 1)
                write_bone_count($urandom_range(1, 12));
            lim = (model_bone_count < MAX_BONES) ? model_bone_count : MAX_BONES;
            if (lim == 0)
                continue;
            roll = $urandom_range(0, 9);
            if (roll < 8)
                send_random_bone(8'($urandom_range(0, lim - 1)));
            else
            begin
                // Stray rows: broken sequences and dropped bones.
                for (int k = 0; k < 4; k++)
                begin
                    lrow[k] = random_elem();
                    brow[k] = random_elem();
                end
                send_bone_row(8'($urandom()), 9'($urandom()), 2'($urandom()), lrow, brow);
            end
        end
    endtask

    task automatic test_output_backpressure();
        int unsigned lim;
        hold_off = 1'b1;
        lim = (model_bone_count < MAX_BONES) ? model_bone_count : MAX_BONES;
        for (int b = 0; b < 3; b++)
            send_random_bone(8'($urandom_range(0, lim - 1)));
        wait (hold_off == 1'b0);
    endtask

    // Output stall: random gaps, a quiet stretch, and one long hold-off.
    initial
    begin
        int roll;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (busy_stall && roll < 40)
            begin
                out_stall <= 1'b1;
                repeat (roll < 37 ? $urandom_range(1, 3) : $urandom_range(10, 40))
                    @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        skin_row_t exp_row;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (skin_rows_due.size() == 0)
            begin
                $error("unexpected result bone %0d row %0d", out_bone, out_row);
                error_count++;
            end
            else
            begin
                exp_row = skin_rows_due.pop_front();
                if (out_bone !== exp_row.bone)
                begin
                    $error("out_bone expected %0d got %0d", exp_row.bone, out_bone);
                    error_count++;
                end
                if (out_row !== exp_row.row)
                begin
                    $error("out_row expected %0d got %0d", exp_row.row, out_row);
                    error_count++;
                end
                if (skin_e0 !== exp_row.e0)
                begin
                    $error("skin_e0 expected %h got %h", exp_row.e0, skin_e0);
                    error_count++;
                end
                if (skin_e1 !== exp_row.e1)
                begin
                    $error("skin_e1 expected %h got %h", exp_row.e1, skin_e1);
                    error_count++;
                end
                if (skin_e2 !== exp_row.e2)
                begin
                    $error("skin_e2 expected %h got %h", exp_row.e2, skin_e2);
                    error_count++;
                end
                if (skin_e3 !== exp_row.e3)
                begin
                    $error("skin_e3 expected %h got %h", exp_row.e3, skin_e3);
                    error_count++;
                end
                if (bone_done !== exp_row.done)
                begin
                    $error("bone_done expected %0d got %0d", exp_row.done, bone_done);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request, result or configuration handshake anywhere.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        bone_count   = '0;
        in_valid     = 1'b0;
        bone_index   = '0;
        parent_index = '0;
        row_number   = '0;
        local_c0 = '0;
        local_c1 = '0;
        local_c2 = '0;
        local_c3 = '0;
        bind_c0  = '0;
        bind_c1  = '0;
        bind_c2  = '0;
        bind_c3  = '0;
        model_bone_count = 0;
        error_count  = 0;
        idle_cycles  = 0;
        results_seen = 0;
        items_sent   = 0;
        hold_off     = 1'b0;
        busy_stall   = 1'b0;
        for (int b = 0; b < MAX_BONES; b++)
            for (int k = 0; k < 16; k++)
                world_mem[b][k] = '0;
        for (int k = 0; k < 12; k++)
        begin
            pend_world[k] = '0;
            pend_bind[k]  = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        busy_stall = 1'b1;
        test_random_skeletons(220);
        write_bone_count(256);
        test_output_backpressure();
        test_random_skeletons(420);
        busy_stall = 1'b0;
        test_random_skeletons(450);
        write_bone_count(1);

        repeat (200) @(posedge clk);
        $display("Sent %0d bone rows over several bone counts; checked %0d skin rows.",
                 items_sent, results_seen);
        if (error_count == 0 && skin_rows_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/smpb_pkg.sv
rtl/core/smpb_ctrl.sv
rtl/core/smpb_datapath.sv
rtl/core/skin_matrix_palette_builder_core.sv
rtl/core/smpb_checker.sv
tb/skin_matrix_palette_builder_core_tb.sv
